### rtl/tce_pkg.sv
`default_nettype none
package tce_pkg;

  localparam int unsigned IdxW  = 11;
  localparam int unsigned ByteW = 8;

  localparam logic [15:0]      BLANK_CELL     = 16'h0F20;
  localparam logic [ByteW-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [ByteW-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [ByteW-1:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [ByteW-1:0] ATTR_RESET     = 8'h0F;

  // register index of text_attribute, taken from paddr[2]
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_PARK  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_PARK_RD,
    S_PARK_CHK,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] char_code;
    logic [IdxW-1:0]  cell_index;
    logic [ByteW-1:0] attr;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] cell_attr;
    logic [ByteW-1:0] cell_char;
    logic [IdxW-1:0]  cursor_position;
  } res_t;

endpackage
`default_nettype wire

### rtl/tce_ram.sv
`default_nettype none
module tce_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/tce_seq.sv
`default_nettype none
module tce_seq #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire tce_pkg::cmd_t cmd_i,
  output      logic          ready_o,
  output      logic          res_valid_o,
  input  wire logic          res_ready_i,
  output      tce_pkg::res_t res_o
);

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ColW  = $clog2(COLUMNS);

  localparam logic [AW-1:0]   ColsA    = AW'(COLUMNS);
  localparam logic [AW-1:0]   CellLast = AW'(Cells - 1);
  localparam logic [AW-1:0]   ScrLast  = AW'(Cells - COLUMNS - 1);
  localparam logic [RowW-1:0] RowLast  = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] ColLast  = ColW'(COLUMNS - 1);

  tce_pkg::seq_state_e state_q, state_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                init_q, init_d;
  tce_pkg::cmd_t       cmd_q, cmd_d;
  logic [7:0]          rchar_q, rchar_d;
  logic [7:0]          rattr_q, rattr_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic [AW-1:0] cur_addr;
  logic          idx_ok;

  assign cur_addr = AW'(row_q) * ColsA + AW'(col_q);
  assign idx_ok   = ({21'd0, cmd_q.cell_index} < 32'(Cells));

  tce_ram #(
    .Width(16),
    .Depth(Cells)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tce_pkg::S_FILL;
      row_q   <= '0;
      col_q   <= '0;
      addr_q  <= '0;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      addr_q  <= addr_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rchar_q <= rchar_d;
    rattr_q <= rattr_d;
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    addr_d    = addr_q;
    init_d    = init_q;
    cmd_d     = cmd_q;
    rchar_d   = rchar_q;
    rattr_d   = rattr_q;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = tce_pkg::BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = cur_addr;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      tce_pkg::S_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          cmd_d   = cmd_i;
          state_d = tce_pkg::S_EXEC;
        end
      end

      tce_pkg::S_EXEC: begin
        rchar_d = '0;
        rattr_d = '0;
        state_d = tce_pkg::S_DONE;
        case (cmd_q.action)
          tce_pkg::ACT_PUT: begin
            if (cmd_q.char_code == tce_pkg::NEWLINE_CHAR) begin
              col_d = '0;
              if (row_q == RowLast) begin
                addr_d  = '0;
                state_d = tce_pkg::S_SCR_RD;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else if (cmd_q.char_code == tce_pkg::BACKSPACE_CHAR) begin
              if (col_q != '0) begin
                col_d     = col_q - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cur_addr - 1'b1;
                mem_wdata = {cmd_q.attr, tce_pkg::SPACE_CHAR};
              end
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {cmd_q.attr, cmd_q.char_code};
              if (col_q == ColLast) begin
                col_d = '0;
                if (row_q == RowLast) begin
                  addr_d  = '0;
                  state_d = tce_pkg::S_SCR_RD;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                col_d = col_q + 1'b1;
              end
            end
          end
          tce_pkg::ACT_READ: begin
            if (idx_ok) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cmd_q.cell_index);
              state_d   = tce_pkg::S_READ_WAIT;
            end
          end
          tce_pkg::ACT_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            addr_d  = '0;
            state_d = tce_pkg::S_FILL;
          end
          tce_pkg::ACT_PARK: begin
            // scan from the bottom row with the cursor as the scan pointer
            row_d   = RowLast;
            col_d   = '0;
            state_d = tce_pkg::S_PARK_RD;
          end
          default: ;
        endcase
      end

      tce_pkg::S_READ_WAIT: begin
        rchar_d = mem_rdata[7:0];
        rattr_d = mem_rdata[15:8];
        state_d = tce_pkg::S_DONE;
      end

      tce_pkg::S_PARK_RD: begin
        mem_re  = 1'b1;
        state_d = tce_pkg::S_PARK_CHK;
      end

      tce_pkg::S_PARK_CHK: begin
        if (mem_rdata[7:0] == tce_pkg::SPACE_CHAR) begin
          if (col_q == ColLast) begin
            col_d   = '0;
            state_d = tce_pkg::S_DONE;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = tce_pkg::S_PARK_RD;
          end
        end else begin
          col_d = '0;
          if (row_q == '0) begin
            // no empty row: scroll, cursor to start of last row
            row_d   = RowLast;
            addr_d  = '0;
            state_d = tce_pkg::S_SCR_RD;
          end else begin
            row_d   = row_q - 1'b1;
            state_d = tce_pkg::S_PARK_RD;
          end
        end
      end

      tce_pkg::S_SCR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = addr_q + ColsA;
        state_d   = tce_pkg::S_SCR_WR;
      end

      tce_pkg::S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = mem_rdata;
        addr_d    = addr_q + 1'b1;
        state_d   = (addr_q == ScrLast) ? tce_pkg::S_FILL : tce_pkg::S_SCR_RD;
      end

      tce_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = tce_pkg::BLANK_CELL;
        if (addr_q == CellLast) begin
          addr_d = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = tce_pkg::S_IDLE;
          end else begin
            state_d = tce_pkg::S_DONE;
          end
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      tce_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tce_pkg::S_IDLE;
        end
      end

      default: state_d = tce_pkg::S_IDLE;
    endcase
  end

  assign res_o.cursor_position = tce_pkg::IdxW'(cur_addr);
  assign res_o.cell_char       = rchar_q;
  assign res_o.cell_attr       = rattr_q;

endmodule
`default_nettype wire

### rtl/text_console_engine.sv
// Channel   Dir  Payload
// s_axis    in   tuser: action[1:0]; tdata: char_code[7:0], cell_index[18:8]
// m_axis    out  tdata: cursor_position[10:0], cell_char[18:11], cell_attr[26:19]
// apb       in   register 0 (byte 0): text_attribute[7:0]
//
// Put, newline and backspace finish in the execute state unless a put or newline scrolls;
// a read also waits for the RAM read data unless its index is out of range, and clear blanks
// every cell in turn. A scroll copies each cell one row up, by a RAM read and a RAM write, then
// blanks the last row; park reads each cell it scans, plus a scroll when no row is empty. Clear
// and scroll walk the screen RAM, one access a cycle, with one address counter. After reset a
// clearing pass blanks the screen; no request is taken meanwhile. A stalled result sits in the
// output register and the next request is still taken; it waits only at its own result.
`default_nettype none
module text_console_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_index[18:8], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,  // cursor_position[10:0], cell_char[18:11],
                                          // cell_attr[26:19], zero pad
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic [7:0]    attr_q;
  tce_pkg::cmd_t cmd;
  tce_pkg::res_t res;
  logic          seq_ready;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_q;
  tce_pkg::res_t out_q;

  // configuration register, to be written by the user only while idle; the block does not enforce this
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tce_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == tce_pkg::REG_TEXT_ATTR) begin
      attr_q <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == tce_pkg::REG_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;

  // request unpack; attribute is sampled with the request
  assign cmd.action     = tce_pkg::action_e'(s_axis_tuser);
  assign cmd.char_code  = s_axis_tdata[7:0];
  assign cmd.cell_index = s_axis_tdata[18:8];
  assign cmd.attr       = attr_q;
  assign s_axis_tready  = seq_ready;

  tce_seq #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid),
    .cmd_i      (cmd),
    .ready_o    (seq_ready),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tce_pkg::*;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELLS      = COLUMNS * ROWS;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int unsigned SETTLE_CYC = 16;
  localparam int unsigned PHASE_REQS = 300;

  // byte address of the attribute register, and one that maps to nothing
  localparam logic [2:0] ADDR_TEXT_ATTR = {REG_TEXT_ATTR, 2'b00};
  localparam logic [2:0] ADDR_SPARE     = {~REG_TEXT_ATTR, 2'b00};

  typedef struct {
    action_e         action;
    logic [7:0]      char_code;
    logic [IdxW-1:0] cell_index;
  } console_req_t;

  // ---------------------------------------------------------------------------
  // clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // char_code[7:0], cell_index[18:8], zero pad
  logic [1:0]  s_axis_tuser  = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;        // cursor_position[10:0], cell_char[18:11],
                                    // cell_attr[26:19], zero pad
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------------
  // screen model
  // ---------------------------------------------------------------------------
  logic [15:0]      screen_model [CELLS];
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [ByteW-1:0] text_attr_model;

  console_req_t pending_reqs[$];
  res_t         expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned scroll_count = 0;
  int unsigned wrap_count = 0;
  int unsigned attr_settings = 0;
  int unsigned action_count [4] = '{0, 0, 0, 0};

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    if (cur_row > 0) cur_row--;
    scroll_count++;
  endfunction

  function automatic void put_char(logic [7:0] code);
    if (code == NEWLINE_CHAR) begin
      cur_row++;
      cur_col = 0;
    end else if (code == BACKSPACE_CHAR) begin
      // backspace in column 0 is a no-op
      if (cur_col > 0) begin
        cur_col--;
        screen_model[cur_row * COLUMNS + cur_col] = {text_attr_model, SPACE_CHAR};
      end
    end else begin
      screen_model[cur_row * COLUMNS + cur_col] = {text_attr_model, code};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
        wrap_count++;
      end
    end
    if (cur_row >= ROWS) scroll_screen();
  endfunction

  // lowest row whose characters are all spaces, attribute ignored;
  // a full screen scrolls and parks on the last row
  function automatic void park_cursor();
    bit empty;
    for (int r = ROWS - 1; r >= 0; r--) begin
      empty = 1'b1;
      for (int c = 0; c < COLUMNS; c++) begin
        if (screen_model[r * COLUMNS + c][7:0] != SPACE_CHAR) empty = 1'b0;
      end
      if (empty) begin
        cur_row = r;
        cur_col = 0;
        return;
      end
    end
    scroll_screen();
    cur_row = ROWS - 1;
    cur_col = 0;
  endfunction

  function automatic res_t console_outcome(console_req_t rq);
    res_t r;
    r = '0;
    action_count[rq.action]++;
    case (rq.action)
      ACT_PUT: begin
        put_char(rq.char_code);
      end
      ACT_READ: begin
        // out-of-range index reads as zero
        if (rq.cell_index < CELLS) begin
          r.cell_char = screen_model[rq.cell_index][7:0];
          r.cell_attr = screen_model[rq.cell_index][15:8];
        end
      end
      ACT_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        park_cursor();
      end
    endcase
    r.cursor_position = IdxW'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("[%0t] MISMATCH: %s", $time, what);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps; result side stalls
  // on a rotating 16-bit pattern that is periodically redrawn
  // ---------------------------------------------------------------------------
  logic        req_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;

  always @(negedge clk_i) begin
    console_req_t rq;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          rq = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= rq.action;
          s_axis_tdata  <= {5'b0, rq.cell_index, rq.char_code};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            // about half the bursts run straight into the next one
            case ($urandom_range(0, 5))
              0, 1, 2: gap_left = 0;
              3, 4:    gap_left = $urandom_range(1, 6);
              default: gap_left = $urandom_range(10, 40);
            endcase
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      m_axis_tready <= stall_pattern[0];
      if (pattern_age == 63) begin
        pattern_age = 0;
        if ($urandom_range(0, 3) == 0) stall_pattern = 16'hFFFF;
        else stall_pattern = 16'($urandom) | 16'h0001;
      end else begin
        pattern_age++;
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, then model newly accepted requests
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t         got;
    res_t         want;
    console_req_t rq;
    if (rst_ni) begin
      req_taken <= s_axis_tvalid && s_axis_tready;

      if (m_axis_tvalid && m_axis_tready) begin
        got.cursor_position = m_axis_tdata[10:0];
        got.cell_char       = m_axis_tdata[18:11];
        got.cell_attr       = m_axis_tdata[26:19];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: cursor %0d char %02h attr %02h",
                                    got.cursor_position, got.cell_char, got.cell_attr));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.cursor_position !== want.cursor_position ||
              got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr) begin
            report_mismatch($sformatf(
                "result %0d: cursor exp %0d got %0d, char exp %02h got %02h, attr exp %02h got %02h",
                results_checked, want.cursor_position, got.cursor_position,
                want.cell_char, got.cell_char, want.cell_attr, got.cell_attr));
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        rq.action     = action_e'(s_axis_tuser);
        rq.char_code  = s_axis_tdata[7:0];
        rq.cell_index = s_axis_tdata[18:8];
        expected_results.push_back(console_outcome(rq));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  int unsigned queued_reqs = 0;

  task automatic queue_req(action_e act, logic [7:0] code, logic [IdxW-1:0] idx);
    console_req_t rq;
    rq.action     = act;
    rq.char_code  = code;
    rq.cell_index = idx;
    pending_reqs.push_back(rq);
    queued_reqs++;
  endtask

  function automatic logic [IdxW-1:0] any_index();
    return IdxW'($urandom);
  endfunction

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // mostly printable, with spaces, control codes and high bytes mixed in
  function automatic logic [7:0] text_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return printable_char();
    if (pick < 88) return SPACE_CHAR;
    if (pick < 92) return BACKSPACE_CHAR;
    if (pick < 94) return NEWLINE_CHAR;
    return 8'($urandom);
  endfunction

  function automatic logic [IdxW-1:0] read_index();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return IdxW'($urandom_range(0, CELLS - 1));
    if (pick < 8) return IdxW'($urandom_range(CELLS - COLUMNS, CELLS - 1));
    if (pick < 9) return IdxW'($urandom_range(CELLS, 2 ** IdxW - 1));
    return any_index();
  endfunction

  task automatic queue_run();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 34) begin
      len = $urandom_range(1, 40);
      repeat (len) queue_req(ACT_PUT, text_char(), any_index());
    end else if (kind < 50) begin
      len = $urandom_range(1, 6);
      repeat (len) queue_req(ACT_READ, 8'($urandom), read_index());
    end else if (kind < 59) begin
      len = $urandom_range(1, 4);
      repeat (len) queue_req(ACT_PUT, NEWLINE_CHAR, any_index());
    end else if (kind < 66) begin
      len = $urandom_range(1, 6);
      repeat (len) queue_req(ACT_PUT, BACKSPACE_CHAR, any_index());
    end else if (kind < 69) begin
      // long line-feed run, which can push the cursor off the bottom
      len = $urandom_range(5, 30);
      repeat (len) queue_req(ACT_PUT, NEWLINE_CHAR, any_index());
    end else if (kind < 74) begin
      queue_req(ACT_CLEAR, 8'($urandom), any_index());
    end else if (kind < 82) begin
      queue_req(ACT_PARK, 8'($urandom), any_index());
    end else if (kind < 88) begin
      // about a full line of text, usually crossing the wrap
      len = $urandom_range(75, 85);
      repeat (len) queue_req(ACT_PUT, printable_char(), any_index());
    end else if (kind < 90) begin
      // one character on every row, then park on a screen with no empty row
      queue_req(ACT_CLEAR, 8'($urandom), any_index());
      repeat (ROWS - 1) begin
        queue_req(ACT_PUT, printable_char(), any_index());
        queue_req(ACT_PUT, NEWLINE_CHAR, any_index());
      end
      queue_req(ACT_PUT, printable_char(), any_index());
      queue_req(ACT_PARK, 8'($urandom), any_index());
      queue_req(ACT_READ, 8'($urandom), IdxW'((ROWS - 2) * COLUMNS));
    end else begin
      len = $urandom_range(1, 8);
      repeat (len) queue_req(action_e'($urandom_range(0, 3)), 8'($urandom), any_index());
    end
  endtask

  task automatic queue_directed();
    queue_req(ACT_READ, 8'hFF, 11'd0);                  // blank after reset
    queue_req(ACT_READ, 8'h00, IdxW'(CELLS - 1));       // last cell
    queue_req(ACT_READ, 8'h55, IdxW'(CELLS));           // first out-of-range index
    queue_req(ACT_READ, 8'hAA, {IdxW{1'b1}});           // largest index
    queue_req(ACT_PUT, 8'h00, {IdxW{1'b1}});
    queue_req(ACT_PUT, 8'hFF, 11'd0);
    queue_req(ACT_PUT, printable_char(), 11'h555);
    queue_req(ACT_PUT, BACKSPACE_CHAR, 11'h2AA);        // blanks column 2
    queue_req(ACT_PUT, NEWLINE_CHAR, any_index());
    queue_req(ACT_PUT, BACKSPACE_CHAR, any_index());    // column 0: nothing happens
    queue_req(ACT_PUT, SPACE_CHAR, any_index());
    queue_req(ACT_READ, 8'h00, 11'd0);
    queue_req(ACT_READ, 8'h00, 11'd1);
    queue_req(ACT_READ, 8'h00, 11'd2);
    queue_req(ACT_PARK, 8'hFF, any_index());            // bottom row is empty
    queue_req(ACT_PUT, printable_char(), any_index());
    queue_req(ACT_PUT, NEWLINE_CHAR, any_index());      // past the last row: scroll
    queue_req(ACT_READ, 8'h00, 11'd0);
    queue_req(ACT_READ, 8'h00, IdxW'((ROWS - 2) * COLUMNS));
    queue_req(ACT_READ, 8'h00, IdxW'((ROWS - 1) * COLUMNS));
    queue_req(ACT_CLEAR, 8'hFF, {IdxW{1'b1}});
    queue_req(ACT_READ, 8'h00, IdxW'(COLUMNS));
    queue_req(ACT_PARK, 8'h00, 11'd0);                  // empty screen
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_TEXT_ATTR) text_attr_model = data[7:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_attribute(logic [7:0] attr);
    apb_write(ADDR_TEXT_ATTR, {24'($urandom), attr});
    attr_settings++;
    // read back over the same port
    @(negedge clk_i);
    psel  <= 1'b1;
    paddr <= ADDR_TEXT_ATTR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {24'b0, text_attr_model})
      report_mismatch($sformatf("attribute readback exp %02h got %08h", text_attr_model, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] phase_attr [6];
    int unsigned phase_start;

    blank_screen();
    cur_row = 0;
    cur_col = 0;
    text_attr_model = ATTR_RESET;
    phase_attr = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom), ATTR_RESET, 8'($urandom)};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // the block blanks its screen store before taking requests
    repeat (CELLS + SETTLE_CYC) @(posedge clk_i);

    set_attribute(8'h00);
    queue_directed();
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      // the spare address must not touch the attribute
      if (p == 1) apb_write(ADDR_SPARE, $urandom);
      set_attribute(phase_attr[p]);
      phase_start = queued_reqs;
      while (queued_reqs - phase_start < PHASE_REQS) queue_run();
      wait_idle();
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Checked %0d results: %0d put, %0d read, %0d clear, %0d park requests",
             results_checked, action_count[ACT_PUT], action_count[ACT_READ],
             action_count[ACT_CLEAR], action_count[ACT_PARK]);
    $display("Attribute settings %0d, line wraps %0d, scrolls %0d",
             attr_settings, wrap_count, scroll_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #(1_500_000_000);
    $display("Timeout with %0d requests queued and %0d results outstanding",
             pending_reqs.size(), expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
rtl/tce_pkg.sv
rtl/tce_ram.sv
rtl/tce_seq.sv
rtl/text_console_engine.sv
dv/testbench.sv
